// ===== sv/wcp_pkg.sv =====
package wcp_pkg;

  localparam int unsigned MASK_W     = 9;
  localparam int unsigned RND_W      = 16;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned WV_W       = 16;
  localparam int unsigned CELL_OUT_W = 4;
  localparam int unsigned TOTAL_W    = 20;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned S_TDATA_W  = 48;
  localparam int unsigned S_TUSER_W  = 3;
  localparam int unsigned M_TDATA_W  = 24;

  localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

  typedef enum logic [S_TUSER_W-1:0] {
    REQ_PICK        = 3'd0,
    REQ_WIN         = 3'd1,
    REQ_LOSS        = 3'd2,
    REQ_NEW_EPISODE = 3'd3,
    REQ_WRITE       = 3'd4
  } req_e;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

// ===== sv/weighted_cell_picker_with_reinforcement.sv =====
// Weighted cell picker with reinforcement learning of the cell weights.
// A request word enters on the s_axis channel; tuser carries the request kind
// (pick, reward win, reward loss, new episode, write weight) and tdata the
// occupied mask, the random word, the cell index and the weight to write.
// Every request yields exactly one result word on the m_axis channel, holding
// the picked cell and the free-cell weight total, with tuser set when a cell
// was found. Non-pick requests return an all-zero word.
// A pick sums the free-cell weights in one pass over the weight memory,
// reduces the random word by a bit-serial modulo unit of sixteen steps and
// walks the cells a second time, stopping early at the picked cell.
// A win or loss update is one read-modify-write pass over all cells; new
// episode, weight writes and unknown kinds go straight to the result stage.
// Once its result word is loaded, the sequencer returns to idle.
// s_axis_tready is high only while the sequencer is idle; one request is
// processed at a time. The result sits in an output register, so a new
// request is accepted while the previous word waits; if the receiver still
// stalls when the next result is ready, the sequencer holds it until the
// register frees up. After reset every weight reads as INITIAL_WEIGHT and
// every pick count as zero, through per-cell valid bits; no clearing pass.
module weighted_cell_picker_with_reinforcement import wcp_pkg::*; #(
  parameter int unsigned CELLS          = 9,
  parameter int unsigned WEIGHT_BITS    = 16,
  parameter int unsigned INITIAL_WEIGHT = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // occupied_mask, random_value, cell_index, weight_value, zero padding
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // req_type
  input  logic [S_TUSER_W-1:0] s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // picked_cell, total_weight
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // pick_found
  output logic                 m_axis_tuser
);

  localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned CW    = $clog2(CELLS + 1);
  localparam int unsigned SUM_W = WEIGHT_BITS + $clog2(CELLS);
  localparam int unsigned DIV_W = SUM_W + 1;
  localparam logic [CW-1:0] CellsC   = CW'(CELLS);
  localparam logic [AW-1:0] LastCell = AW'(CELLS - 1);
  localparam logic [WEIGHT_BITS-1:0] InitW = WEIGHT_BITS'(INITIAL_WEIGHT);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SUM  = 3'd1;
  localparam logic [2:0] ST_MOD  = 3'd2;
  localparam logic [2:0] ST_WALK = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   pv_q, pv_d;
  logic [AW-1:0]          pidx_q;
  logic [CELLS-1:0]       wv_q, wv_d;
  logic [CELLS-1:0]       cv_q, cv_d;
  logic                   rd_wv_q, rd_cv_q;
  req_e                   req_q, req_d;
  logic [MASK_W-1:0]      mask_q, mask_d;
  logic [RND_W-1:0]       rnd_q, rnd_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [SUM_W-1:0]       rem_q, rem_d;
  logic [SUM_W-1:0]       thr_q, thr_d;
  logic [CELL_OUT_W-1:0]  res_cell_q, res_cell_d;
  logic                   res_found_q, res_found_d;
  logic                   m_tvalid_q, m_tvalid_d;
  logic [M_TDATA_W-1:0]   m_tdata_q;
  logic                   m_tuser_q;

  logic                   pass_active;
  logic                   rd_ok;
  logic                   load_out;
  logic [AW-1:0]          rd_addr;
  logic [CELLS-1:0]       free_vec;
  logic                   is_last;

  req_e                   in_req;
  logic [IDX_W-1:0]       in_idx;
  logic [WV_W-1:0]        in_wv;

  logic                   w_we;
  logic [AW-1:0]          w_waddr;
  logic [WEIGHT_BITS-1:0] w_wdata;
  logic [WEIGHT_BITS-1:0] w_rdata;
  logic [WEIGHT_BITS-1:0] w_eff;
  logic                   c_we;
  logic [CNT_W-1:0]       c_rdata;
  logic [CNT_W-1:0]       c_eff;
  logic [CNT_W-1:0]       c_inc;

  logic [WEIGHT_BITS:0]   cnt_ext;
  logic [WEIGHT_BITS:0]   win_sum;
  logic [WEIGHT_BITS-1:0] upd_w;
  logic [SUM_W:0]         walk_diff;
  logic                   walk_ok;

  logic                   mod_start;
  mod_stat_t              mod_stat;
  logic [DIV_W-1:0]       mod_rem;

  assign in_req = req_e'(s_axis_tuser);
  assign in_idx = s_axis_tdata[28:25];
  assign in_wv  = s_axis_tdata[44:29];

  assign pass_active = (state_q == ST_SUM) || (state_q == ST_WALK) || (state_q == ST_UPD);
  assign rd_ok       = cnt_q < CellsC;
  assign rd_addr     = rd_ok ? cnt_q[AW-1:0] : '0;
  assign pv_d        = pass_active && rd_ok;
  assign free_vec    = ~CELLS'(mask_q);
  assign is_last     = pidx_q == LastCell;

  assign w_eff = rd_wv_q ? w_rdata : InitW;
  assign c_eff = rd_cv_q ? c_rdata : '0;
  assign c_inc = (c_eff == CNT_MAX) ? c_eff : c_eff + 1'b1;

  assign cnt_ext = (WEIGHT_BITS + 1)'(c_eff);
  assign win_sum = {1'b0, w_eff} + cnt_ext;

  always_comb begin
    upd_w = w_eff;
    if (req_q == REQ_WIN) begin
      upd_w = win_sum[WEIGHT_BITS] ? '1 : win_sum[WEIGHT_BITS-1:0];
    end else if (w_eff > WEIGHT_BITS'(1)) begin
      upd_w = ({1'b0, w_eff} > cnt_ext + 1'b1) ?
              w_eff - WEIGHT_BITS'(c_eff) : WEIGHT_BITS'(1);
    end
  end

  assign walk_diff = {1'b0, rem_q} - (SUM_W + 1)'(w_eff);
  assign walk_ok   = !walk_diff[SUM_W] && (walk_diff[SUM_W-1:0] >= thr_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    wv_d        = wv_q;
    cv_d        = cv_q;
    req_d       = req_q;
    mask_d      = mask_q;
    rnd_d       = rnd_q;
    sum_d       = sum_q;
    rem_d       = rem_q;
    thr_d       = thr_q;
    res_cell_d  = res_cell_q;
    res_found_d = res_found_q;
    w_we        = 1'b0;
    w_waddr     = pidx_q;
    w_wdata     = upd_w;
    c_we        = 1'b0;
    mod_start   = 1'b0;
    load_out    = 1'b0;
    if (pv_d) begin
      cnt_d = cnt_q + 1'b1;
    end
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          req_d       = in_req;
          mask_d      = s_axis_tdata[8:0];
          rnd_d       = s_axis_tdata[24:9];
          sum_d       = '0;
          res_cell_d  = '0;
          res_found_d = 1'b0;
          cnt_d       = '0;
          case (in_req)
            REQ_PICK: begin
              state_d = ST_SUM;
            end
            REQ_WIN, REQ_LOSS: begin
              state_d = ST_UPD;
            end
            REQ_NEW_EPISODE: begin
              cv_d    = '0;
              state_d = ST_FIN;
            end
            REQ_WRITE: begin
              if (32'(in_idx) < 32'(CELLS)) begin
                w_we          = 1'b1;
                w_waddr       = AW'(in_idx);
                w_wdata       = WEIGHT_BITS'(in_wv);
                wv_d[w_waddr] = 1'b1;
              end
              state_d = ST_FIN;
            end
            default: begin
              state_d = ST_FIN;
            end
          endcase
        end
      end
      ST_SUM: begin
        if (pv_q) begin
          if (free_vec[pidx_q]) begin
            sum_d = sum_q + SUM_W'(w_eff);
          end
          if (is_last) begin
            state_d = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        mod_start = !mod_stat.busy && !mod_stat.done;
        if (mod_stat.done) begin
          thr_d   = SUM_W'(mod_rem);
          rem_d   = sum_q;
          cnt_d   = '0;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (pv_q) begin
          if (free_vec[pidx_q] && !walk_ok) begin
            res_cell_d   = CELL_OUT_W'(pidx_q);
            res_found_d  = 1'b1;
            c_we         = 1'b1;
            cv_d[pidx_q] = 1'b1;
            state_d      = ST_FIN;
          end else begin
            if (free_vec[pidx_q]) begin
              rem_d = walk_diff[SUM_W-1:0];
            end
            if (is_last) begin
              state_d = ST_FIN;
            end
          end
        end
      end
      ST_UPD: begin
        if (pv_q) begin
          w_we         = 1'b1;
          wv_d[pidx_q] = 1'b1;
          if (is_last) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (!m_tvalid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    m_tvalid_d = m_tvalid_q;
    if (load_out) begin
      m_tvalid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_tvalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      pv_q       <= 1'b0;
      wv_q       <= '0;
      cv_q       <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      pv_q       <= pv_d;
      wv_q       <= wv_d;
      cv_q       <= cv_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q      <= rd_addr;
    rd_wv_q     <= wv_q[rd_addr];
    rd_cv_q     <= cv_q[rd_addr];
    req_q       <= req_d;
    mask_q      <= mask_d;
    rnd_q       <= rnd_d;
    sum_q       <= sum_d;
    rem_q       <= rem_d;
    thr_q       <= thr_d;
    res_cell_q  <= res_cell_d;
    res_found_q <= res_found_d;
    if (load_out) begin
      m_tdata_q <= {TOTAL_W'(sum_q), res_cell_q};
      m_tuser_q <= res_found_q;
    end
  end

  wcp_ram #(
    .Width(WEIGHT_BITS),
    .Depth(CELLS)
  ) u_weight_ram (
    .clk_i  (clk_i),
    .we_i   (w_we),
    .waddr_i(w_waddr),
    .wdata_i(w_wdata),
    .raddr_i(rd_addr),
    .rdata_o(w_rdata)
  );

  wcp_ram #(
    .Width(CNT_W),
    .Depth(CELLS)
  ) u_count_ram (
    .clk_i  (clk_i),
    .we_i   (c_we),
    .waddr_i(pidx_q),
    .wdata_i(c_inc),
    .raddr_i(rd_addr),
    .rdata_o(c_rdata)
  );

  wcp_mod #(
    .DivW(DIV_W)
  ) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start),
    .dividend_i(rnd_q),
    .divisor_i ({1'b0, sum_q} + 1'b1),
    .stat_o    (mod_stat),
    .rem_o     (mod_rem)
  );

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

endmodule

// ===== sv/wcp_ram.sv =====
module wcp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/wcp_mod.sv =====
module wcp_mod import wcp_pkg::*; #(
  parameter int unsigned DivW = 21
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [RND_W-1:0] dividend_i,
  input  logic [DivW-1:0] divisor_i,
  output mod_stat_t       stat_o,
  output logic [DivW-1:0] rem_o
);

  localparam int unsigned StepW = $clog2(RND_W);
  localparam logic [StepW-1:0] LastStep = StepW'(RND_W - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic [RND_W-1:0] dvd_q, dvd_d;
  logic [DivW-1:0]  rem_q, rem_d;
  logic [DivW-1:0]  div_q, div_d;
  logic [DivW:0]    trial;
  logic [DivW:0]    diff;

  assign trial = {rem_q, dvd_q[RND_W-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = diff[DivW] ? trial[DivW-1:0] : diff[DivW-1:0];
      dvd_d  = {dvd_q[RND_W-2:0], 1'b0};
      step_d = step_q + 1'b1;
      if (step_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

endmodule

// ===== sv/wcp_checker.sv =====
module wcp_checker import wcp_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [S_TDATA_W-1:0] s_axis_tdata,
  input logic [S_TUSER_W-1:0] s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tuser
);

  // A stalled result word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word withdrawn while stalled");

  // A stalled result word keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // Only one request is in work at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in work");

  // A word without a found cell reports cell zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[CELL_OUT_W-1:0] == '0)
    else $error("cell reported although none was found");

endmodule

bind weighted_cell_picker_with_reinforcement wcp_checker u_wcp_checker (.*);
